FILE: rtl/ssst_pkg.sv
// ----------------------------------------------------------------------------
// ssst_pkg: shared types and constants of the sorted set store
// Depth of the cell chain, field widths, action and status codes, and the
// control beat that every cell receives.
// ----------------------------------------------------------------------------
package ssst_pkg;

  localparam int DEPTH = 16;
  localparam int VAL_W = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CAP_W = 5;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_PRESENT = 2'd2,
    ST_ABSENT  = 2'd3
  } status_t;

  // Update command broadcast to the chain for one accepted beat.
  typedef struct packed {
    logic add;
    logic remove;
  } cell_ctrl_t;

endpackage

FILE: rtl/ssst_cell.sv
// ----------------------------------------------------------------------------
// ssst_cell: one slot of the sorted chain
// Holds one value, compares it with the probe and, on an update, takes the
// probe or a neighbor's value so the chain stays in ascending order.
// ----------------------------------------------------------------------------
module ssst_cell (
  input  logic                             clk,
  input  ssst_pkg::cell_ctrl_t             ctrl,
  input  logic signed [ssst_pkg::VAL_W-1:0] probe,
  input  logic                             occ,
  input  logic signed [ssst_pkg::VAL_W-1:0] left_val,
  input  logic                             left_above,
  input  logic                             left_past,
  input  logic signed [ssst_pkg::VAL_W-1:0] right_val,
  output logic signed [ssst_pkg::VAL_W-1:0] val,
  output logic                             above,
  output logic                             past,
  output logic                             eq
);

  logic signed [ssst_pkg::VAL_W-1:0] val_next;

  assign eq    = occ && (val == probe);
  // At or beyond the insertion point: empty slots count as above.
  assign above = !occ || (val > probe);
  // At or beyond the matching slot.
  assign past  = eq || left_past;

  always_comb begin
    val_next = val;
    if (ctrl.add && above) begin
      val_next = left_above ? left_val : probe;
    end else if (ctrl.remove && past) begin
      val_next = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val <= val_next;
  end

endmodule

FILE: rtl/sorted_set_store.sv
// An accepted input beat gives its result beat from the result register in the next cycle.
// Throughput: one item per cycle while results are taken at once; all slots
//   compare and shift in the same cycle through the cell chain. A result that
//   waits in the output register holds off the next input beat.
// Reset: count cleared to zero and capacity_limit set to 16; slot contents are
//   not cleared and are never read until written.
// ----------------------------------------------------------------------------
// sorted_set_store: bounded sorted set of signed 32-bit values
// Add, remove and look up values kept in ascending order in a chain of cells,
// with an APB register for the capacity limit.
// ----------------------------------------------------------------------------
module sorted_set_store (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [1:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          action,
  input  logic signed [ssst_pkg::VAL_W-1:0]   value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          status,
  output logic                                found,
  output logic [ssst_pkg::IDX_W-1:0]          rank,
  output logic [ssst_pkg::CNT_W-1:0]          count
);

  localparam int N = ssst_pkg::DEPTH;

  logic [ssst_pkg::CAP_W-1:0] capacity_limit;
  logic [ssst_pkg::CNT_W-1:0] elem_count;
  logic [ssst_pkg::CNT_W-1:0] elem_count_next;
  logic [ssst_pkg::CNT_W-1:0] limit;

  logic                         accept;
  logic                         any_eq;
  logic [ssst_pkg::IDX_W-1:0]   match_idx;
  logic                         add_ok;
  logic                         rem_ok;
  ssst_pkg::status_t            status_next;
  ssst_pkg::cell_ctrl_t         ctrl;

  logic [N-1:0]                        occ;
  logic [N-1:0]                        above;
  logic [N-1:0]                        past;
  logic [N-1:0]                        eq;
  logic signed [ssst_pkg::VAL_W-1:0]   cell_val [N];

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = {{(32-ssst_pkg::CAP_W){1'b0}}, capacity_limit};

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= ssst_pkg::CAP_W'(N);
    end else if (psel && penable && pwrite && pready && paddr == 2'b00) begin
      capacity_limit <= pwdata[ssst_pkg::CAP_W-1:0];
    end
  end

  assign limit = (ssst_pkg::CNT_W'(capacity_limit) > ssst_pkg::CNT_W'(N))
                 ? ssst_pkg::CNT_W'(N) : ssst_pkg::CNT_W'(capacity_limit);

  // Cell chain.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      occ[i] = ssst_pkg::CNT_W'(i) < elem_count;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic signed [ssst_pkg::VAL_W-1:0] lv;
    logic signed [ssst_pkg::VAL_W-1:0] rv;
    logic                              la;
    logic                              lp;
    if (g == 0) begin : g_first
      assign lv = value;
      assign la = 1'b0;
      assign lp = 1'b0;
    end else begin : g_inner
      assign lv = cell_val[g-1];
      assign la = above[g-1];
      assign lp = past[g-1];
    end
    if (g == N - 1) begin : g_last
      assign rv = cell_val[g];
    end else begin : g_mid
      assign rv = cell_val[g+1];
    end

    ssst_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .probe      (value),
      .occ        (occ[g]),
      .left_val   (lv),
      .left_above (la),
      .left_past  (lp),
      .right_val  (rv),
      .val        (cell_val[g]),
      .above      (above[g]),
      .past       (past[g]),
      .eq         (eq[g])
    );
  end

  // Match encode: values are distinct, so at most one slot matches.
  always_comb begin
    any_eq    = |eq;
    match_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (eq[i]) begin
        match_idx = match_idx | ssst_pkg::IDX_W'(i);
      end
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    add_ok      = 1'b0;
    rem_ok      = 1'b0;
    status_next = any_eq ? ssst_pkg::ST_DONE : ssst_pkg::ST_ABSENT;
    case (action)
      ssst_pkg::ACT_ADD: begin
        if (elem_count >= limit) begin
          status_next = ssst_pkg::ST_FULL;
        end else if (any_eq) begin
          status_next = ssst_pkg::ST_PRESENT;
        end else begin
          status_next = ssst_pkg::ST_DONE;
          add_ok      = 1'b1;
        end
      end
      ssst_pkg::ACT_REMOVE: begin
        rem_ok = any_eq;
      end
      default: begin
        // lookup, and the unused code behaves as lookup
      end
    endcase
  end

  assign ctrl.add    = accept && add_ok;
  assign ctrl.remove = accept && rem_ok;

  always_comb begin
    elem_count_next = elem_count;
    if (ctrl.add) begin
      elem_count_next = elem_count + 1'b1;
    end else if (ctrl.remove) begin
      elem_count_next = elem_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      elem_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      elem_count <= elem_count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result register: hold until the beat is taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      found  <= any_eq;
      rank   <= any_eq ? match_idx : '0;
      count  <= elem_count_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    elem_count <= ssst_pkg::CNT_W'(N))
    else $error("element count above depth");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(eq))
    else $error("more than one slot matches the probe");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.add |=> elem_count == $past(elem_count) + 1'b1)
    else $error("count did not grow after add");

  a_rank_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> rank == '0)
    else $error("rank set on a miss");

  a_count_out: assert property (@(posedge clk) disable iff (rst)
    accept |=> count == elem_count)
    else $error("reported count differs from stored count");

endmodule
